@@ rtl/u8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dec_pkg: shared types and constants of the UTF-8 decoder
// Widths of the result fields, the result record and the character codes
// that steer the line and column counters.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int CP_W      = 31;
  localparam int LEN_W     = 3;
  localparam int POS_W     = 32;
  localparam int IN_DATA_W = 8;
  // Six result fields packed without gaps, padded up to whole bytes.
  localparam int OUT_FIELD_W = CP_W + LEN_W + 4 * POS_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [CP_W-1:0] CP_CR = 31'h0000_000D;
  localparam logic [CP_W-1:0] CP_LF = 31'h0000_000A;

  localparam logic [IN_DATA_W-1:0] CONT_MASK = 8'h3F;
  localparam logic [IN_DATA_W-1:0] LEAD_MASK = 8'h7F;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] char_bytes;
    logic [POS_W-1:0] line_number;
    logic [POS_W-1:0] column_number;
    logic [POS_W-1:0] byte_position;
    logic [POS_W-1:0] char_position;
    logic             at_end;
    logic             bad_lead;
  } result_t;

endpackage

@@ rtl/utf8_decoder_with_position.sv @@
// ----------------------------------------------------------------------------
// utf8_decoder_with_position: streaming UTF-8 decoder with source positions
// Decodes the original one- to six-byte UTF-8 forms and tags each character
// with its line, column, byte offset and character offset.
// ----------------------------------------------------------------------------
// One byte is taken per transaction; a new byte is accepted in every cycle
// while the skid register is empty. A result follows the byte that completes
// a character and each end-of-input transaction (in_tuser high), which always
// yields an end result with out_tlast high. Lead bytes with bits 7 and 5..1
// set yield a one-byte result flagged by out_tuser. The decode state and the
// position counters sit in one register stage, the result in an output
// register backed by one skid register, so the input keeps flowing while a
// result waits on out_tready. Position counters are COUNTER_BITS wide and
// wrap; the output shows their low 32 bits, zero extended if narrower.
module utf8_decoder_with_position #(
  parameter int COUNTER_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] in_byte
  input  logic [u8dec_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] end_of_stream
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [30:0] code_point, [33:31] char_bytes, [65:34] line_number,
  // [97:66] column_number, [129:98] byte_position, [161:130] char_position,
  // upper bits zero
  output logic [u8dec_pkg::OUT_DATA_W-1:0]  out_tdata,
  // at_end
  output logic                              out_tlast,
  // [0] bad_lead
  output logic                              out_tuser
);

  localparam int CW    = COUNTER_BITS;
  localparam int PW    = u8dec_pkg::POS_W;
  localparam int CPW   = u8dec_pkg::CP_W;
  localparam int LW    = u8dec_pkg::LEN_W;
  localparam int BW    = u8dec_pkg::IN_DATA_W;
  localparam int PAD_W = u8dec_pkg::OUT_DATA_W - u8dec_pkg::OUT_FIELD_W;

  // Decode state.
  logic [CPW-1:0] partial_r, partial_nxt;
  logic [LW-1:0]  left_r, left_nxt;
  logic [LW-1:0]  seq_len_r, seq_len_nxt;
  logic [CW-1:0]  line_r, line_nxt;
  logic [CW-1:0]  column_r, column_nxt;
  logic [CW-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [CW-1:0]  char_cnt_r, char_cnt_nxt;
  logic           after_cr_r, after_cr_nxt;

  // Output register and skid register.
  u8dec_pkg::result_t out_r, skid_r, res;
  logic               out_valid_r, skid_valid_r;

  logic           accept;
  logic           has_res;
  logic           do_adv;
  logic [CPW-1:0] adv_cp;
  logic [LW-1:0]  adv_len;
  logic [BW-1:0]  in_byte;
  logic [LW-1:0]  lead_len;
  logic [CPW-1:0] cont_code;

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign in_byte   = in_tdata;
  assign cont_code = {partial_r[CPW-7:0], in_byte[5:0] & u8dec_pkg::CONT_MASK[5:0]};

  // Sequence length from the first clear bit of the lead among bits 7 and 5..1.
  always_comb begin
    if (!in_byte[7]) begin
      lead_len = 3'd1;
    end else if (!in_byte[5]) begin
      lead_len = 3'd2;
    end else if (!in_byte[4]) begin
      lead_len = 3'd3;
    end else if (!in_byte[3]) begin
      lead_len = 3'd4;
    end else if (!in_byte[2]) begin
      lead_len = 3'd5;
    end else if (!in_byte[1]) begin
      lead_len = 3'd6;
    end else begin
      lead_len = 3'd0;
    end
  end

  // Decode step.
  always_comb begin
    partial_nxt = partial_r;
    left_nxt    = left_r;
    seq_len_nxt = seq_len_r;
    has_res     = 1'b0;
    do_adv      = 1'b0;
    adv_cp      = '0;
    adv_len     = '0;
    res               = '0;
    res.line_number   = PW'(line_r);
    res.column_number = PW'(column_r);
    res.byte_position = PW'(byte_cnt_r);
    res.char_position = PW'(char_cnt_r);

    if (in_tuser) begin
      // End of input drops any sequence in progress without counting it.
      has_res     = 1'b1;
      res.at_end  = 1'b1;
      partial_nxt = '0;
      left_nxt    = '0;
      seq_len_nxt = '0;
    end else if (left_r != '0) begin
      left_nxt = left_r - 3'd1;
      if (left_r == 3'd1) begin
        has_res     = 1'b1;
        do_adv      = 1'b1;
        adv_cp      = cont_code;
        adv_len     = seq_len_r;
        partial_nxt = '0;
        seq_len_nxt = '0;
      end else begin
        partial_nxt = cont_code;
      end
    end else if (lead_len == 3'd0 || lead_len == 3'd1) begin
      has_res      = 1'b1;
      do_adv       = 1'b1;
      adv_cp       = CPW'(in_byte);
      adv_len      = 3'd1;
      res.bad_lead = (lead_len == 3'd0);
    end else begin
      partial_nxt = CPW'(in_byte & (u8dec_pkg::LEAD_MASK >> (lead_len - 3'd1)));
      seq_len_nxt = lead_len;
      left_nxt    = lead_len - 3'd1;
    end

    if (do_adv) begin
      res.code_point = adv_cp;
      res.char_bytes = adv_len;
    end
  end

  // Position counters advance after each finished character.
  always_comb begin
    line_nxt     = line_r;
    column_nxt   = column_r;
    byte_cnt_nxt = byte_cnt_r;
    char_cnt_nxt = char_cnt_r;
    after_cr_nxt = after_cr_r;
    if (do_adv) begin
      if (adv_cp == u8dec_pkg::CP_CR) begin
        column_nxt   = '0;
        line_nxt     = line_r + 1'b1;
        after_cr_nxt = 1'b1;
      end else if (adv_cp == u8dec_pkg::CP_LF) begin
        column_nxt   = '0;
        after_cr_nxt = 1'b0;
        // LF right after CR closes the same line break.
        if (!after_cr_r) begin
          line_nxt = line_r + 1'b1;
        end
      end else begin
        after_cr_nxt = 1'b0;
        column_nxt   = column_r + 1'b1;
      end
      byte_cnt_nxt = byte_cnt_r + CW'(adv_len);
      char_cnt_nxt = char_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r  <= '0;
      left_r     <= '0;
      seq_len_r  <= '0;
      line_r     <= '0;
      column_r   <= '0;
      byte_cnt_r <= '0;
      char_cnt_r <= '0;
      after_cr_r <= 1'b0;
    end else if (accept) begin
      partial_r  <= partial_nxt;
      left_r     <= left_nxt;
      seq_len_r  <= seq_len_nxt;
      line_r     <= line_nxt;
      column_r   <= column_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      char_cnt_r <= char_cnt_nxt;
      after_cr_r <= after_cr_nxt;
    end
  end

  // The skid register catches a result that arrives while the output stalls;
  // input is held off only while the skid register is full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept && has_res;
      end
    end else if (accept && has_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end else if (accept && has_res) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_r.char_position, out_r.byte_position,
                       out_r.column_number, out_r.line_number, out_r.char_bytes,
                       out_r.code_point};
  assign out_tlast  = out_r.at_end;
  assign out_tuser  = out_r.bad_lead;

  // The skid register only fills behind a held output result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // At most five continuation bytes are ever outstanding.
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= 3'd5 && (left_r == '0 || seq_len_r == left_r + 3'd1 ||
                       left_r < seq_len_r))
    else $error("continuation count out of range");

  // An end result carries no character and is never an invalid lead.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.at_end |->
      out_r.code_point == '0 && out_r.char_bytes == '0 && !out_r.bad_lead)
    else $error("end result carries character data");

  // A result that completes a sequence advances the character count by one.
  a_char_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && has_res && !in_tuser |=> char_cnt_r == $past(char_cnt_r) + 1'b1)
    else $error("character count did not advance");

endmodule
